>>> rtl/rtpp_pkg.sv
// Shared constants, register codes and helper functions of the RTP packet pacer.
`timescale 1ns / 1ps

package rtpp_pkg;

    localparam logic [31:0] SPREAD_RESET    = 32'd100000;
    localparam logic [31:0] AHEAD_RESET     = 32'd200000;
    localparam logic [15:0] MEDIA_LEN_RESET = 16'd1450;

    // A multiply by this value followed by a shift of MS_RECIP_SHIFT gives an exact
    // floor division by 1000 for every 32-bit operand.
    localparam logic [31:0] MS_RECIP       = 32'd2199023256;
    localparam int          MS_RECIP_SHIFT = 41;
    localparam int          SPREAD_Q_W     = 64 - MS_RECIP_SHIFT;

    localparam logic [63:0] WARN_INTERVAL_US = 64'd1000000;

    localparam int PROD_W    = 49;
    localparam int DVD_W     = 59;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic MEDIA_VIDEO = 1'b1;

    typedef enum logic [1:0] {
        CFG_MAX_SPREAD    = 2'd0,
        CFG_MAX_AHEAD     = 2'd1,
        CFG_MAX_MEDIA_LEN = 2'd2
    } cfg_index_t;

    function automatic logic [31:0] rtp_scale(input logic kind, input logic [31:0] ts);
        logic [31:0] video;
        video = (ts << 6) + (ts << 4) + (ts << 3) + (ts << 1);
        return (kind == MEDIA_VIDEO) ? video : (ts << 3);
    endfunction

    function automatic logic [DVD_W-1:0] ms_to_us(input logic [PROD_W-1:0] x);
        return {x, 10'd0} - {6'd0, x, 4'd0} - {7'd0, x, 3'd0};
    endfunction

endpackage

>>> rtl/rtp_packet_pacer.sv
// Top level of the RTP packet pacer: wire time, release time and pacing cursor.
`timescale 1ns / 1ps

//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | one packet descriptor word
//  out     | output    | out_valid / out_ready | one release word per kept packet
//  cfg     | input     | cfg_valid / cfg_ready | register index and data
//
// A kept packet runs through ST_CHECK, ST_CLAMP, ST_SCALE, ST_DIVIDE and ST_FINISH, and
// ST_DIVIDE is skipped when the frame length is zero or the quotient saturates; in_ready
// and out_valid rise together. A dropped packet frees the input straight from ST_CHECK.
// The wire time quotient comes from a bit-serial divider that retires one bit per cycle,
// and that divider sets the pace.
// One packet is in work at a time; the next word is taken while the result waits.
// Async reset clears the cursor, warning time and state; the limits take their defaults.
// A stalled result holds the last stage until the output register is free.

module rtp_packet_pacer
    import rtpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        media_kind,
    input  logic [31:0] frame_timestamp_ms,
    input  logic [31:0] frame_duration_ms,
    input  logic [31:0] frame_total_length,
    input  logic [15:0] prefix_length,
    input  logic [15:0] payload_size,
    input  logic        last_in_frame,
    input  logic [63:0] now_us,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] release_time_us,
    output logic [31:0] wire_time_us,
    output logic [31:0] rtp_timestamp,
    output logic [15:0] media_length,
    output logic        marker,
    output logic        ahead_clipped,
    output logic        rate_warning,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CLAMP,
        ST_SCALE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [31:0]            max_spread_reg, max_spread_next;
    logic [31:0]            max_ahead_reg, max_ahead_next;
    logic [15:0]            max_len_reg, max_len_next;
    logic [63:0]            cursor_reg, cursor_next;
    logic [63:0]            last_warn_reg, last_warn_next;

    logic                   kind_reg, kind_next;
    logic                   last_reg, last_next;
    logic [31:0]            ts_reg, ts_next;
    logic [31:0]            dur_reg, dur_next;
    logic [31:0]            flen_reg, flen_next;
    logic [16:0]            len_reg, len_next;
    logic [63:0]            now_reg, now_next;
    logic [63:0]            release_reg, release_next;
    logic [SPREAD_Q_W-1:0]  spread_q_reg, spread_q_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [63:0]            limit_reg, limit_next;
    logic                   warn_due_reg, warn_due_next;
    logic [31:0]            rem_reg, rem_next;
    logic [31:0]            dq_reg, dq_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic                   out_valid_reg, out_valid_next;
    logic [63:0]            out_release_reg, out_release_next;
    logic [31:0]            out_wire_reg, out_wire_next;
    logic [31:0]            out_rtp_reg, out_rtp_next;
    logic [15:0]            out_len_reg, out_len_next;
    logic                   out_marker_reg, out_marker_next;
    logic                   out_clip_reg, out_clip_next;
    logic                   out_warn_reg, out_warn_next;

    logic [63:0]            spread_prod;
    logic [31:0]            dur_eff;
    logic [DVD_W-1:0]       dividend;
    logic [32:0]            div_trial;
    logic                   div_ge;
    logic [64:0]            limit_sum;
    logic [64:0]            cursor_sum;
    logic [63:0]            cursor_sat;
    logic                   clip;

    assign spread_prod = max_spread_reg * MS_RECIP;
    assign dur_eff     = (dur_reg > {{(32-SPREAD_Q_W){1'b0}}, spread_q_reg})
                       ? {{(32-SPREAD_Q_W){1'b0}}, spread_q_reg} : dur_reg;
    assign dividend    = ms_to_us(prod_reg);
    assign div_trial   = {rem_reg, dq_reg[31]};
    assign div_ge      = div_trial >= {1'b0, flen_reg};
    assign limit_sum   = {1'b0, release_reg} + {33'd0, max_ahead_reg};
    assign cursor_sum  = {1'b0, release_reg} + {33'd0, dq_reg};
    assign cursor_sat  = cursor_sum[64] ? {64{1'b1}} : cursor_sum[63:0];
    assign clip        = cursor_sat > limit_reg;

    always_comb
    begin
        state_next       = state_reg;
        max_spread_next  = max_spread_reg;
        max_ahead_next   = max_ahead_reg;
        max_len_next     = max_len_reg;
        cursor_next      = cursor_reg;
        last_warn_next   = last_warn_reg;
        kind_next        = kind_reg;
        last_next        = last_reg;
        ts_next          = ts_reg;
        dur_next         = dur_reg;
        flen_next        = flen_reg;
        len_next         = len_reg;
        now_next         = now_reg;
        release_next     = release_reg;
        spread_q_next    = spread_q_reg;
        prod_next        = prod_reg;
        limit_next       = limit_reg;
        warn_due_next    = warn_due_reg;
        rem_next         = rem_reg;
        dq_next          = dq_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        out_release_next = out_release_reg;
        out_wire_next    = out_wire_reg;
        out_rtp_next     = out_rtp_reg;
        out_len_next     = out_len_reg;
        out_marker_next  = out_marker_reg;
        out_clip_next    = out_clip_reg;
        out_warn_next    = out_warn_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_SPREAD:    max_spread_next = cfg_data;
                CFG_MAX_AHEAD:     max_ahead_next  = cfg_data;
                CFG_MAX_MEDIA_LEN: max_len_next    = cfg_data[15:0];
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = media_kind;
                    last_next  = last_in_frame;
                    ts_next    = frame_timestamp_ms;
                    dur_next   = frame_duration_ms;
                    flen_next  = frame_total_length;
                    len_next   = {1'b0, prefix_length} + {1'b0, payload_size};
                    now_next   = now_us;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                spread_q_next = spread_prod[63:MS_RECIP_SHIFT];
                release_next  = (cursor_reg < now_reg) ? now_reg : cursor_reg;
                state_next    = (len_reg > {1'b0, max_len_reg}) ? ST_IDLE : ST_CLAMP;
            end
            ST_CLAMP:
            begin
                prod_next     = len_reg * dur_eff;
                limit_next    = limit_sum[64] ? {64{1'b1}} : limit_sum[63:0];
                warn_due_next = (release_reg - last_warn_reg) > WARN_INTERVAL_US;
                state_next    = ST_SCALE;
            end
            ST_SCALE:
            begin
                cnt_next = '0;
                if (flen_reg == 32'd0)
                begin
                    dq_next    = 32'd0;
                    state_next = ST_FINISH;
                end
                else if ({5'd0, dividend[DVD_W-1:32]} >= flen_reg)
                begin
                    dq_next    = {32{1'b1}};
                    state_next = ST_FINISH;
                end
                else
                begin
                    rem_next   = {5'd0, dividend[DVD_W-1:32]};
                    dq_next    = dividend[31:0];
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                rem_next = div_ge ? 32'(div_trial - {1'b0, flen_reg}) : div_trial[31:0];
                dq_next  = {dq_reg[30:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cursor_next      = clip ? limit_reg : cursor_sat;
                    if (clip && warn_due_reg)
                    begin
                        last_warn_next = release_reg;
                    end
                    out_valid_next   = 1'b1;
                    out_release_next = release_reg;
                    out_wire_next    = dq_reg;
                    out_rtp_next     = rtp_scale(kind_reg, ts_reg);
                    out_len_next     = len_reg[15:0];
                    out_marker_next  = last_reg;
                    out_clip_next    = clip;
                    out_warn_next    = clip && warn_due_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            max_spread_reg  <= SPREAD_RESET;
            max_ahead_reg   <= AHEAD_RESET;
            max_len_reg     <= MEDIA_LEN_RESET;
            cursor_reg      <= '0;
            last_warn_reg   <= '0;
            kind_reg        <= 1'b0;
            last_reg        <= 1'b0;
            ts_reg          <= '0;
            dur_reg         <= '0;
            flen_reg        <= '0;
            len_reg         <= '0;
            now_reg         <= '0;
            release_reg     <= '0;
            spread_q_reg    <= '0;
            prod_reg        <= '0;
            limit_reg       <= '0;
            warn_due_reg    <= 1'b0;
            rem_reg         <= '0;
            dq_reg          <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_release_reg <= '0;
            out_wire_reg    <= '0;
            out_rtp_reg     <= '0;
            out_len_reg     <= '0;
            out_marker_reg  <= 1'b0;
            out_clip_reg    <= 1'b0;
            out_warn_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            max_spread_reg  <= max_spread_next;
            max_ahead_reg   <= max_ahead_next;
            max_len_reg     <= max_len_next;
            cursor_reg      <= cursor_next;
            last_warn_reg   <= last_warn_next;
            kind_reg        <= kind_next;
            last_reg        <= last_next;
            ts_reg          <= ts_next;
            dur_reg         <= dur_next;
            flen_reg        <= flen_next;
            len_reg         <= len_next;
            now_reg         <= now_next;
            release_reg     <= release_next;
            spread_q_reg    <= spread_q_next;
            prod_reg        <= prod_next;
            limit_reg       <= limit_next;
            warn_due_reg    <= warn_due_next;
            rem_reg         <= rem_next;
            dq_reg          <= dq_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            out_release_reg <= out_release_next;
            out_wire_reg    <= out_wire_next;
            out_rtp_reg     <= out_rtp_next;
            out_len_reg     <= out_len_next;
            out_marker_reg  <= out_marker_next;
            out_clip_reg    <= out_clip_next;
            out_warn_reg    <= out_warn_next;
        end
    end

    assign in_ready        = (state_reg == ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign release_time_us = out_release_reg;
    assign wire_time_us    = out_wire_reg;
    assign rtp_timestamp   = out_rtp_reg;
    assign media_length    = out_len_reg;
    assign marker          = out_marker_reg;
    assign ahead_clipped   = out_clip_reg;
    assign rate_warning    = out_warn_reg;

    // The cursor never moves back, since each new value is at least the release time.
    a_cursor_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg >= $past(cursor_reg))
        else $error("pacing cursor moved backwards");

    a_warn_needs_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_warn_reg || out_clip_reg))
        else $error("rate warning without clipping");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (rem_reg < flen_reg))
        else $error("divider remainder not below divisor");

    a_cursor_after_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (cursor_reg >= out_release_reg))
        else $error("cursor behind the last release time");

endmodule

>>> tb/rtp_packet_pacer_checker.sv
// Checker for the RTP packet pacer: predicts each release word and compares it with the block.
`timescale 1ns / 1ps

module rtp_packet_pacer_checker
    import rtpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        media_kind,
    input  logic [31:0] frame_timestamp_ms,
    input  logic [31:0] frame_duration_ms,
    input  logic [31:0] frame_total_length,
    input  logic [15:0] prefix_length,
    input  logic [15:0] payload_size,
    input  logic        last_in_frame,
    input  logic [63:0] now_us,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] release_time_us,
    input  logic [31:0] wire_time_us,
    input  logic [31:0] rtp_timestamp,
    input  logic [15:0] media_length,
    input  logic        marker,
    input  logic        ahead_clipped,
    input  logic        rate_warning,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned checked
);

    localparam logic [63:0] US_PER_MS   = 64'd1000;
    localparam logic [31:0] VIDEO_SCALE = 32'd90;
    localparam logic [31:0] AUDIO_SCALE = 32'd8;

    typedef struct {
        logic [63:0] release_us;
        logic [31:0] wire_us;
        logic [31:0] rtp_ts;
        logic [15:0] len;
        logic        mark;
        logic        clipped;
        logic        warn;
    } paced_word_t;

    logic [31:0] spread_lim;
    logic [31:0] ahead_lim;
    logic [15:0] len_lim;
    logic [63:0] cursor;
    logic [63:0] warned_at;

    paced_word_t paced_q[$];
    paced_word_t fresh;
    paced_word_t oldest;
    int unsigned errs;
    int unsigned done;

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic bit pace_packet(output paced_word_t w);
        logic [16:0] len;
        logic [63:0] dur;
        logic [63:0] quo;
        logic [63:0] nxt;
        logic [63:0] lim;
        len = {1'b0, prefix_length} + {1'b0, payload_size};
        if (len > {1'b0, len_lim})
            return 1'b0;
        dur = {32'd0, frame_duration_ms};
        if (dur * US_PER_MS > {32'd0, spread_lim})
            dur = {32'd0, spread_lim} / US_PER_MS;
        w.wire_us = '0;
        if (frame_total_length != '0)
        begin
            quo = ({47'd0, len} * dur * US_PER_MS) / {32'd0, frame_total_length};
            w.wire_us = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
        end
        w.release_us = (cursor < now_us) ? now_us : cursor;
        nxt = add_sat(w.release_us, {32'd0, w.wire_us});
        lim = add_sat(w.release_us, {32'd0, ahead_lim});
        w.clipped = 1'b0;
        w.warn = 1'b0;
        if (nxt > lim)
        begin
            nxt = lim;
            w.clipped = 1'b1;
            if (w.release_us - warned_at > WARN_INTERVAL_US)
            begin
                warned_at = w.release_us;
                w.warn = 1'b1;
            end
        end
        cursor = nxt;
        w.rtp_ts = frame_timestamp_ms * ((media_kind == MEDIA_VIDEO) ? VIDEO_SCALE : AUDIO_SCALE);
        w.len = len[15:0];
        w.mark = last_in_frame;
        return 1'b1;
    endfunction

    function automatic void cmp_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            errs++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spread_lim = SPREAD_RESET;
            ahead_lim = AHEAD_RESET;
            len_lim = MEDIA_LEN_RESET;
            cursor = '0;
            warned_at = '0;
            paced_q.delete();
            errs = 0;
            done = 0;
            fail_count <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_SPREAD:    spread_lim = cfg_data;
                    CFG_MAX_AHEAD:     ahead_lim = cfg_data;
                    CFG_MAX_MEDIA_LEN: len_lim = cfg_data[15:0];
                    default:           ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (pace_packet(fresh))
                    paced_q.push_back(fresh);
            end
            if (out_valid && out_ready)
            begin
                if (paced_q.size() == 0)
                begin
                    $error("Release word arrived with no packet waiting for it.");
                    errs++;
                end
                else
                begin
                    oldest = paced_q.pop_front();
                    cmp_field("release_time_us", oldest.release_us, release_time_us);
                    cmp_field("wire_time_us", {32'd0, oldest.wire_us}, {32'd0, wire_time_us});
                    cmp_field("rtp_timestamp", {32'd0, oldest.rtp_ts}, {32'd0, rtp_timestamp});
                    cmp_field("media_length", {48'd0, oldest.len}, {48'd0, media_length});
                    cmp_field("marker", {63'd0, oldest.mark}, {63'd0, marker});
                    cmp_field("ahead_clipped", {63'd0, oldest.clipped}, {63'd0, ahead_clipped});
                    cmp_field("rate_warning", {63'd0, oldest.warn}, {63'd0, rate_warning});
                    done++;
                end
            end
            fail_count <= errs;
            pending <= paced_q.size();
            checked <= done;
        end
    end

endmodule

>>> tb/rtp_packet_pacer_tb.sv
// Testbench top of the RTP packet pacer: reset, register settings, packet stimulus and verdict.
`timescale 1ns / 1ps

module rtp_packet_pacer_tb;
    import rtpp_pkg::*;

    localparam logic [1:0] CFG_SPARE     = 2'd3;
    localparam int         PHASE_ITEMS   = 135;
    localparam int         RANDOM_PHASES = 9;
    localparam int         SETTLE_CYCLES = 60;
    localparam longint     TIMEOUT_NS    = 64'd20_000_000;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_LONG_STALLS,
        READY_COIN
    } ready_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        media_kind = 1'b0;
    logic [31:0] frame_timestamp_ms = '0;
    logic [31:0] frame_duration_ms = '0;
    logic [31:0] frame_total_length = '0;
    logic [15:0] prefix_length = '0;
    logic [15:0] payload_size = '0;
    logic        last_in_frame = 1'b0;
    logic [63:0] now_us = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] release_time_us;
    logic [31:0] wire_time_us;
    logic [31:0] rtp_timestamp;
    logic [15:0] media_length;
    logic        marker;
    logic        ahead_clipped;
    logic        rate_warning;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    ready_mode_t ready_mode = READY_ALWAYS;
    logic [7:0]  mode_cycles = '0;
    int unsigned stall_left = 0;

    int unsigned burst_left = 0;
    int unsigned sent = 0;
    int unsigned settings = 0;
    logic [15:0] mlen_cur = MEDIA_LEN_RESET;
    logic [63:0] now_clock = 64'd10000;
    logic [31:0] ts_clock = '0;
    bit          wide_time = 1'b0;

    rtp_packet_pacer dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .media_kind         (media_kind),
        .frame_timestamp_ms (frame_timestamp_ms),
        .frame_duration_ms  (frame_duration_ms),
        .frame_total_length (frame_total_length),
        .prefix_length      (prefix_length),
        .payload_size       (payload_size),
        .last_in_frame      (last_in_frame),
        .now_us             (now_us),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .release_time_us    (release_time_us),
        .wire_time_us       (wire_time_us),
        .rtp_timestamp      (rtp_timestamp),
        .media_length       (media_length),
        .marker             (marker),
        .ahead_clipped      (ahead_clipped),
        .rate_warning       (rate_warning),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    rtp_packet_pacer_checker chk (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .media_kind         (media_kind),
        .frame_timestamp_ms (frame_timestamp_ms),
        .frame_duration_ms  (frame_duration_ms),
        .frame_total_length (frame_total_length),
        .prefix_length      (prefix_length),
        .payload_size       (payload_size),
        .last_in_frame      (last_in_frame),
        .now_us             (now_us),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .release_time_us    (release_time_us),
        .wire_time_us       (wire_time_us),
        .rtp_timestamp      (rtp_timestamp),
        .media_length       (media_length),
        .marker             (marker),
        .ahead_clipped      (ahead_clipped),
        .rate_warning       (rate_warning),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .fail_count         (fail_count),
        .pending            (pending),
        .checked            (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        mode_cycles <= mode_cycles + 8'd1;
        if (mode_cycles == '0)
            ready_mode <= ready_mode_t'($urandom_range(0, 2));
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (ready_mode == READY_LONG_STALLS && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 60);
            out_ready <= 1'b0;
        end
        else if (ready_mode == READY_COIN)
            out_ready <= 1'($urandom_range(0, 1));
        else
            out_ready <= 1'b1;
    end

    task automatic send_pkt(input logic kind, input logic [31:0] ts, input logic [31:0] dur,
                            input logic [31:0] flen, input logic [15:0] pre,
                            input logic [15:0] pay, input logic last, input logic [63:0] t);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        media_kind <= kind;
        frame_timestamp_ms <= ts;
        frame_duration_ms <= dur;
        frame_total_length <= flen;
        prefix_length <= pre;
        payload_size <= pay;
        last_in_frame <= last;
        now_us <= t;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic write_settings(input logic [31:0] spread, input logic [31:0] ahead,
                                  input logic [15:0] mlen);
        put_reg(CFG_MAX_SPREAD, spread);
        put_reg(CFG_MAX_AHEAD, ahead);
        put_reg(CFG_MAX_MEDIA_LEN, {16'd0, mlen});
        put_reg(CFG_SPARE, $urandom);
        cfg_valid <= 1'b0;
        mlen_cur = mlen;
        settings++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_noise();
        logic [15:0] pre;
        logic [15:0] pay;
        logic [63:0] t;
        pre = 16'($urandom);
        pay = 16'($urandom);
        if ($urandom_range(0, 3) == 0 && mlen_cur != '1)
        begin
            pre = '0;
            pay = mlen_cur + 16'd1;
        end
        if (wide_time)
            t = {$urandom, $urandom};
        else if (now_clock > 64'd500000)
            t = now_clock - 64'($urandom_range(0, 500000));
        else
            t = now_clock;
        send_pkt(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, pre, pay,
                 1'($urandom_range(0, 1)), t);
    endtask

    task automatic send_frame(inout int count);
        logic        kind;
        logic [31:0] dur;
        logic [31:0] flen;
        int unsigned lens[6];
        int unsigned pres[6];
        int unsigned npk;
        int unsigned total;
        int unsigned lt;
        bit          cut_short;
        kind = 1'($urandom_range(0, 1));
        ts_clock += kind ? $urandom_range(30, 40) : 32'd20;
        case ($urandom_range(0, 7))
            0:       dur = '0;
            1:       dur = $urandom;
            default: dur = $urandom_range(1, 120);
        endcase
        npk = $urandom_range(1, 6);
        total = 0;
        for (int k = 0; k < npk; k++)
        begin
            lt = $urandom_range(0, mlen_cur);
            pres[k] = $urandom_range(0, (lt < 24) ? lt : 24);
            lens[k] = lt;
            total += lt;
        end
        case ($urandom_range(0, 9))
            0:       flen = '0;
            1:       flen = $urandom;
            2:       flen = $urandom_range(1, 8);
            default: flen = total;
        endcase
        cut_short = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < npk; k++)
        begin
            case ($urandom_range(0, 23))
                0:       now_clock -= (now_clock > 64'd2000000) ? $urandom_range(0, 2000000) : 0;
                1:       now_clock += $urandom_range(1000000, 3000000);
                default: now_clock += $urandom_range(0, 20000);
            endcase
            send_pkt(kind, ts_clock, dur, flen, 16'(pres[k]), 16'(lens[k] - pres[k]),
                     (k == npk - 1) && !cut_short, now_clock);
            count++;
        end
    endtask

    task automatic run_phase(input int p);
        logic [31:0] spread;
        logic [31:0] ahead;
        logic [15:0] mlen;
        int          count;
        case (p)
            0:
            begin
                spread = '0;
                ahead = '0;
                mlen = '1;
            end
            1:
            begin
                spread = '1;
                ahead = '1;
                mlen = '0;
            end
            2:
            begin
                spread = SPREAD_RESET;
                ahead = AHEAD_RESET;
                mlen = MEDIA_LEN_RESET;
            end
            3:
            begin
                spread = '1;
                ahead = '0;
                mlen = 16'd1500;
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       spread = '0;
                    1:       spread = '1;
                    2:       spread = $urandom_range(1000, 500000);
                    default: spread = $urandom;
                endcase
                case ($urandom_range(0, 3))
                    0:       ahead = '0;
                    1:       ahead = '1;
                    2:       ahead = $urandom_range(0, 2000000);
                    default: ahead = $urandom;
                endcase
                case ($urandom_range(0, 3))
                    0:       mlen = 16'($urandom_range(0, 64));
                    1:       mlen = '1;
                    2:       mlen = 16'($urandom_range(500, 9000));
                    default: mlen = 16'($urandom);
                endcase
            end
        endcase
        write_settings(spread, ahead, mlen);
        now_clock += 64'($urandom) << $urandom_range(0, 4);
        count = 0;
        while (count < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                send_noise();
                count++;
            end
            else
                send_frame(count);
        end
        drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_pkt(1'b0, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0, 64'd0);
        send_pkt(1'b1, '1, 32'd20, 32'd1450, 16'd12, 16'd1438, 1'b1, 64'd1000);
        send_pkt(1'b0, '1, 32'd20, 32'd3000, 16'd0, 16'd1451, 1'b0, 64'd2000);
        send_pkt(1'b1, 32'd123, 32'd20, 32'd0, '1, '1, 1'b1, 64'd3000);
        send_pkt(1'b0, 32'd5, '1, 32'd1000, 16'd10, 16'd990, 1'b1, 64'd4000);
        send_pkt(1'b1, 32'd6, 32'd100, 32'd1000, 16'd0, 16'd500, 1'b0, 64'd5000);
        send_pkt(1'b1, 32'd6, 32'd101, 32'd1000, 16'd0, 16'd500, 1'b1, 64'd5000);
        send_pkt(1'b0, 32'd7, 32'd100, 32'd1, 16'd0, 16'd1000, 1'b1, 64'd5000000);
        send_pkt(1'b0, 32'd8, 32'd100, 32'd1, 16'd0, 16'd1000, 1'b1, 64'd5000000);
        send_pkt(1'b1, 32'd9, 32'd100, 32'd1, 16'd0, 16'd1000, 1'b0, 64'd10);
        send_pkt(1'b0, 32'd10, 32'd40, 32'd2, 16'd1, 16'd0, 1'b1, 64'd7000000);
        send_pkt(1'b1, 32'd11, 32'd40, 32'd1, '1, 16'd0, 1'b0, 64'd7000000);
        send_pkt(1'b1, 32'd12, 32'd40, 32'd1, 16'd0, '1, 1'b1, 64'd7000000);
        drain();

        write_settings('1, '1, '1);
        send_pkt(1'b1, 32'd13, '1, 32'd1, 16'd0, '1, 1'b1, 64'd8000000);
        send_pkt(1'b0, '1, '1, '1, '1, 16'd0, 1'b0, 64'd8000000);
        send_pkt(1'b1, 32'd14, '1, '1, 16'd0, '1, 1'b1, 64'd9000000);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
            run_phase(p);

        // Times near the top of the range come last, since they pin the cursor high.
        write_settings('1, '1, '1);
        wide_time = 1'b1;
        repeat (36) send_noise();
        send_pkt(1'b1, $urandom, '1, 32'd1, 16'd0, '1, 1'b1, 64'hFFFF_FFFF_FFFF_F000);
        send_pkt(1'b0, $urandom, '1, 32'd1, '1, 16'd0, 1'b0, '1);
        send_pkt(1'b1, $urandom, 32'd50, 32'd100, 16'd4, 16'd96, 1'b1, 64'd12345);
        drain();

        $display("Sent %0d packet descriptors under %0d register settings.", sent, settings);
        $display("Checked %0d release words under random output stalls.", checked);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d release words still outstanding.", pending);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/rtpp_pkg.sv
rtl/rtp_packet_pacer.sv
tb/rtp_packet_pacer_checker.sv
tb/rtp_packet_pacer_tb.sv
